@@ rtl/mtep_pkg.sv @@
`default_nettype none
package mtep_pkg;

  // one byte of the track chunk body
  typedef struct packed {
    logic [7:0] track_byte;
    logic       first_of_track;
    logic       last_of_track;
  } item_t;

  // one parser result
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick;
    logic [7:0]  event_type;
    logic [3:0]  channel;
    logic [27:0] data_length;
    logic [7:0]  payload;
    logic        last_data;
    logic [1:0]  error_code;
  } result_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_META_TYPE,
    PH_LEN_VLQ,
    PH_DATA,
    PH_DONE
  } phase_t;

  // parser state that does not depend on the vlq length limit
  typedef struct packed {
    phase_t      phase;
    logic [27:0] vlq_acc;
    logic [31:0] tick;
    logic [7:0]  running_type;
    logic [3:0]  channel;
    logic [27:0] event_length;
    logic [27:0] bytes_remaining;
    logic        error_latched;
  } parse_state_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_VLQ_LONG  = 2'd1;
  localparam logic [1:0] ERR_RUNNING   = 2'd2;
  localparam logic [1:0] ERR_TRACK_END = 2'd3;

  // status bytes and meta types
  localparam logic [7:0] META_MARKER   = 8'hFF;
  localparam logic [7:0] META_END      = 8'h2F;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
  localparam logic [7:0] ST_SONG_POS   = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
  localparam logic [3:0] NIB_SYSTEM    = 4'hF;
  localparam logic [3:0] NIB_PROGRAM   = 4'hC;
  localparam logic [3:0] NIB_PRESSURE  = 4'hD;

  function automatic result_t mk_result(
    input logic [1:0]  kind,
    input logic [31:0] tick,
    input logic [7:0]  etype,
    input logic [3:0]  chan,
    input logic [27:0] len,
    input logic [7:0]  pay,
    input logic        last,
    input logic [1:0]  err
  );
    result_t r;
    r.kind        = kind;
    r.tick        = tick;
    r.event_type  = etype;
    r.channel     = chan;
    r.data_length = len;
    r.payload     = pay;
    r.last_data   = last;
    r.error_code  = err;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mtep_step.sv @@
`default_nettype none
module mtep_step #(
  parameter int MAX_VLQ_BYTES = 4,
  localparam int CW = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1
) (
  input  var mtep_pkg::item_t        item,
  input  var mtep_pkg::parse_state_t st,
  input  wire logic [CW-1:0]         cnt,
  output mtep_pkg::parse_state_t     st_next,
  output logic [CW-1:0]              cnt_next,
  output logic [1:0]                 n_res,
  output mtep_pkg::result_t          res0,
  output mtep_pkg::result_t          res1
);

  mtep_pkg::parse_state_t cur;
  logic [CW-1:0] cnt_cur;
  logic [7:0]    b;
  logic          last;
  logic          cont;
  logic          too_long;
  logic [27:0]   acc_or;
  logic [27:0]   acc_more;
  logic [27:0]   rem_dec;
  logic          fail;
  logic [1:0]    fail_code;
  logic          start;
  logic [7:0]    start_type;
  logic [27:0]   start_len;

  // start of a track clears position, running status and error
  always_comb begin
    cur     = st;
    cnt_cur = cnt;
    if (item.first_of_track) begin
      cur.phase           = mtep_pkg::PH_DELTA;
      cur.vlq_acc         = '0;
      cnt_cur             = '0;
      cur.tick            = '0;
      cur.running_type    = mtep_pkg::META_MARKER;
      cur.bytes_remaining = '0;
      cur.error_latched   = 1'b0;
    end
  end

  // vlq byte decode
  always_comb begin
    b        = item.track_byte;
    last     = item.last_of_track;
    cont     = b[7];
    too_long = cont && ((int'(cnt_cur) + 1) >= MAX_VLQ_BYTES);
    acc_or   = cur.vlq_acc | {21'd0, b[6:0]};
    acc_more = {acc_or[20:0], 7'd0};
  end

  // one byte of parsing
  always_comb begin
    st_next    = cur;
    cnt_next   = cnt_cur;
    n_res      = 2'd0;
    res0       = '0;
    res1       = '0;
    fail       = 1'b0;
    fail_code  = mtep_pkg::ERR_NONE;
    start      = 1'b0;
    start_type = '0;
    start_len  = '0;
    rem_dec    = '0;

    if (!cur.error_latched) begin
      unique case (cur.phase)
        mtep_pkg::PH_DELTA: begin
          if (too_long) begin
            fail = 1'b1; fail_code = mtep_pkg::ERR_VLQ_LONG;
          end else if (last) begin
            fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
          end else if (cont) begin
            st_next.vlq_acc = acc_more;
            cnt_next        = cnt_cur + CW'(1);
          end else begin
            st_next.tick    = cur.tick + {4'd0, acc_or};
            st_next.vlq_acc = '0;
            cnt_next        = '0;
            st_next.phase   = mtep_pkg::PH_STATUS;
          end
        end

        mtep_pkg::PH_STATUS: begin
          if (!b[7]) begin
            // running status: header of the previous event plus this data byte
            if (!cur.running_type[7] || cur.running_type[7:4] == mtep_pkg::NIB_SYSTEM) begin
              fail = 1'b1; fail_code = mtep_pkg::ERR_RUNNING;
            end else if (last) begin
              fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
            end else begin
              rem_dec = (cur.event_length == '0) ? '0 : cur.event_length - 28'd1;
              st_next.bytes_remaining = rem_dec;
              st_next.phase = (rem_dec == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA;
              res0 = mtep_pkg::mk_result(mtep_pkg::KIND_HEADER, cur.tick,
                       cur.running_type, cur.channel, cur.event_length, 8'd0, 1'b0,
                       mtep_pkg::ERR_NONE);
              res1 = mtep_pkg::mk_result(mtep_pkg::KIND_DATA, cur.tick,
                       cur.running_type, cur.channel, cur.event_length, b,
                       rem_dec == '0, mtep_pkg::ERR_NONE);
              n_res = 2'd2;
            end
          end else if (b[7:4] != mtep_pkg::NIB_SYSTEM) begin
            // channel message
            if (last) begin
              fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
            end else begin
              st_next.channel = b[3:0];
              start      = 1'b1;
              start_type = {b[7:4], 4'd0};
              start_len  = (b[7:4] == mtep_pkg::NIB_PROGRAM ||
                            b[7:4] == mtep_pkg::NIB_PRESSURE) ? 28'd1 : 28'd2;
            end
          end else if (b == mtep_pkg::META_MARKER) begin
            if (last) begin
              fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
            end else begin
              st_next.phase = mtep_pkg::PH_META_TYPE;
            end
          end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
            if (last) begin
              fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
            end else begin
              st_next.running_type = b;
              st_next.vlq_acc      = '0;
              cnt_next             = '0;
              st_next.phase        = mtep_pkg::PH_LEN_VLQ;
            end
          end else begin
            // other system messages have fixed lengths
            if (last) begin
              fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
            end else begin
              start      = 1'b1;
              start_type = b;
              start_len  = (b == mtep_pkg::ST_SONG_POS) ? 28'd2 :
                           (b == mtep_pkg::ST_SONG_SEL) ? 28'd1 : 28'd0;
            end
          end
        end

        mtep_pkg::PH_META_TYPE: begin
          if (b == mtep_pkg::META_END) begin
            st_next.running_type = b;
            st_next.phase        = mtep_pkg::PH_DONE;
            res0 = mtep_pkg::mk_result(mtep_pkg::KIND_END, cur.tick, b, cur.channel,
                     28'd0, 8'd0, 1'b0, mtep_pkg::ERR_NONE);
            n_res = 2'd1;
          end else if (last) begin
            fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
          end else begin
            st_next.running_type = b;
            st_next.vlq_acc      = '0;
            cnt_next             = '0;
            st_next.phase        = mtep_pkg::PH_LEN_VLQ;
          end
        end

        mtep_pkg::PH_LEN_VLQ: begin
          if (too_long) begin
            fail = 1'b1; fail_code = mtep_pkg::ERR_VLQ_LONG;
          end else if (last) begin
            fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
          end else if (cont) begin
            st_next.vlq_acc = acc_more;
            cnt_next        = cnt_cur + CW'(1);
          end else begin
            st_next.vlq_acc = '0;
            cnt_next        = '0;
            start      = 1'b1;
            start_type = cur.running_type;
            start_len  = acc_or;
          end
        end

        mtep_pkg::PH_DATA: begin
          if (last) begin
            fail = 1'b1; fail_code = mtep_pkg::ERR_TRACK_END;
          end else begin
            rem_dec = (cur.bytes_remaining == '0) ? '0 : cur.bytes_remaining - 28'd1;
            st_next.bytes_remaining = rem_dec;
            if (rem_dec == '0) begin
              st_next.phase = mtep_pkg::PH_DELTA;
            end
            res0 = mtep_pkg::mk_result(mtep_pkg::KIND_DATA, cur.tick, cur.running_type,
                     cur.channel, cur.event_length, b, rem_dec == '0,
                     mtep_pkg::ERR_NONE);
            n_res = 2'd1;
          end
        end

        default: begin
        end
      endcase

      // event header for a known length
      if (start) begin
        st_next.running_type    = start_type;
        st_next.event_length    = start_len;
        st_next.bytes_remaining = start_len;
        st_next.phase = (start_len == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA;
        res0 = mtep_pkg::mk_result(mtep_pkg::KIND_HEADER, cur.tick, start_type,
                 st_next.channel, start_len, 8'd0, 1'b0, mtep_pkg::ERR_NONE);
        n_res = 2'd1;
      end

      // sticky error, one error result
      if (fail) begin
        st_next               = cur;
        st_next.error_latched = 1'b1;
        res0 = mtep_pkg::mk_result(mtep_pkg::KIND_ERROR, cur.tick, cur.running_type,
                 cur.channel, 28'd0, 8'd0, 1'b0, fail_code);
        res1  = '0;
        n_res = 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/mtep_out_fifo.sv @@
`default_nettype none
module mtep_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_n,
  input  var mtep_pkg::result_t  push0,
  input  var mtep_pkg::result_t  push1,
  output mtep_pkg::result_t      result,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic                   room_two
);

  mtep_pkg::result_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign result_valid = (count != 3'd0);
  assign result       = mem[rd_ptr];
  assign pop          = result_valid && !result_stall;
  assign room_two     = (count - {2'd0, pop}) <= 3'd2;

  // entry storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'd0, pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/midi_track_event_parser.sv @@
`default_nettype none
// Parses the body bytes of a MIDI track chunk, one byte per transfer, into event headers,
// data bytes, an end-of-track marker and sticky errors. One byte is taken every clock
// cycle while item_stall is low: an accepted byte sits in an input register and is parsed
// once a four-entry result queue can take two more results; its results (none, one, or two
// for a running-status data byte) are written into that queue, from which they are offered
// on the output. The input stalls only while that queue has fewer than two free
// entries; since the output drains at most one result per cycle, and none while
// result_stall is high, a long run of running-status events is limited by the output side
// to one result per cycle. MAX_VLQ_BYTES sets the longest delta time or length VLQ.
module midi_track_event_parser #(
  parameter int MAX_VLQ_BYTES = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  var mtep_pkg::item_t   item,
  input  wire logic             item_valid,
  output logic                  item_stall,
  output mtep_pkg::result_t     result,
  output logic                  result_valid,
  input  wire logic             result_stall
);

  localparam int CW = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1;

  mtep_pkg::item_t        item_q;
  logic                   item_q_valid;
  mtep_pkg::parse_state_t st;
  mtep_pkg::parse_state_t st_next;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          cnt_next;
  logic [1:0]             n_res;
  mtep_pkg::result_t      res0;
  mtep_pkg::result_t      res1;
  logic                   room_two;
  logic                   fire;

  // parse the held byte when the queue can take two results
  assign fire       = item_q_valid && room_two;
  assign item_stall = item_q_valid && !room_two;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  mtep_step #(
    .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
  ) u_step (
    .item     (item_q),
    .st       (st),
    .cnt      (cnt),
    .st_next  (st_next),
    .cnt_next (cnt_next),
    .n_res    (n_res),
    .res0     (res0),
    .res1     (res1)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= mtep_pkg::PH_DELTA;
      st.vlq_acc         <= '0;
      st.tick            <= '0;
      st.running_type    <= mtep_pkg::META_MARKER;
      st.channel         <= '0;
      st.event_length    <= '0;
      st.bytes_remaining <= '0;
      st.error_latched   <= 1'b0;
      cnt                <= '0;
    end else if (fire) begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  mtep_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_n       (fire ? n_res : 2'd0),
    .push0        (res0),
    .push1        (res1),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .room_two     (room_two)
  );

endmodule
`default_nettype wire
